/* hdl/bals_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the bounded array list store: field widths, the default
// capacity and the command codes. No dependencies.
package bals_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int LEN_W  = 7;
  localparam int VAL_W  = 32;
  localparam int FIDX_W = 6;
  localparam int CNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RESIZE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd6;

endpackage

/* hdl/bals_ram.sv */
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module bals_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bounded_array_list_store_core.sv */
`timescale 1ns / 1ps
// Bounded array list store: top level, command sequencer around one word RAM.
// Depends on bals_pkg and bals_ram.

// Keeps an ordered list of up to DEPTH 32-bit words in a single RAM with one write
// and one registered read port, plus a live count in a register. One command is
// worked at a time; a new beat is taken as soon as the sequencer is back in idle,
// even while the previous result still waits at the output register. Fill and
// resize write one word at a time through the single RAM write port (resize only
// when growing, with zeros), insert and append shift the tail up one word at a
// time, find reads one word at a time through the read port until a match or the
// count; read and write each touch one word, and a rejected command touches none.
// No clearing pass is needed after reset.
module bounded_array_list_store_core
  import bals_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [POS_W-1:0]  in_position,
  input  logic [LEN_W-1:0]  in_length,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_ok,
  output logic [VAL_W-1:0]  out_read_value,
  output logic              out_found,
  output logic [FIDX_W-1:0] out_found_index,
  output logic [CNT_W-1:0]  out_element_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_PUT   = 3'd3;
  localparam logic [2:0] ST_RWAIT = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     end_r, end_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     dst_r, dst_nxt;
  logic              pend_r, pend_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [VAL_W-1:0]  res_rd_r, res_rd_nxt;
  logic              res_fnd_r, res_fnd_nxt;
  logic [FIDX_W-1:0] res_fidx_r, res_fidx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  logic [XW-1:0]     pos_x, len_x, cnt_x, ins_x;
  logic [CW-1:0]     cur_dec;

  bals_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_x   = XW'(in_position);
  assign len_x   = XW'(in_length);
  assign cnt_x   = XW'(count_r);
  assign ins_x   = (in_command == CMD_APPEND) ? cnt_x : pos_x;
  assign cur_dec = cur_r - CW'(1);

  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    end_nxt      = end_r;
    pos_nxt      = pos_r;
    dst_nxt      = dst_r;
    pend_nxt     = pend_r;
    val_nxt      = val_r;
    res_ok_nxt   = res_ok_r;
    res_rd_nxt   = res_rd_r;
    res_fnd_nxt  = res_fnd_r;
    res_fidx_nxt = res_fidx_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = val_r;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_ok_nxt   = 1'b0;
          res_rd_nxt   = '0;
          res_fnd_nxt  = 1'b0;
          res_fidx_nxt = '0;
          val_nxt      = in_value;
          pend_nxt     = 1'b0;
          state_nxt    = ST_DONE;
          unique case (in_command) inside
            CMD_FILL, CMD_RESIZE: begin
              if (len_x <= DEPTH_X) begin
                res_ok_nxt = 1'b1;
                end_nxt    = CW'(len_x);
                state_nxt  = ST_FILL;
                if (in_command == CMD_FILL) begin
                  cur_nxt = '0;
                end else begin
                  cur_nxt = count_r;
                  val_nxt = '0;
                end
              end
            end
            CMD_INSERT, CMD_APPEND: begin
              if (ins_x <= cnt_x && cnt_x < DEPTH_X) begin
                res_ok_nxt = 1'b1;
                pos_nxt    = CW'(ins_x);
                cur_nxt    = count_r;
                state_nxt  = ST_SHIFT;
              end
            end
            CMD_READ: begin
              if (pos_x < cnt_x) begin
                res_ok_nxt = 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = pos_x[AW-1:0];
                state_nxt  = ST_RWAIT;
              end
            end
            CMD_WRITE: begin
              if (pos_x < cnt_x) begin
                res_ok_nxt = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = pos_x[AW-1:0];
                ram_wdata  = in_value;
              end
            end
            CMD_FIND: begin
              res_ok_nxt = 1'b1;
              cur_nxt    = '0;
              state_nxt  = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        if (cur_r < end_r) begin
          ram_we    = 1'b1;
          ram_waddr = cur_r[AW-1:0];
          ram_wdata = val_r;
          cur_nxt   = cur_r + CW'(1);
        end else begin
          count_nxt = end_r;
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = ram_rdata;
        end
        if (cur_r > pos_r) begin
          ram_re    = 1'b1;
          ram_raddr = cur_dec[AW-1:0];
          dst_nxt   = cur_r[AW-1:0];
          cur_nxt   = cur_dec;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = ST_DONE;
      end
      ST_RWAIT: begin
        res_rd_nxt = ram_rdata;
        state_nxt  = ST_DONE;
      end
      ST_SCAN: begin
        if (pend_r && ram_rdata == val_r) begin
          res_fnd_nxt  = 1'b1;
          res_fidx_nxt = FIDX_W'(dst_r);
          pend_nxt     = 1'b0;
          state_nxt    = ST_DONE;
        end else if (cur_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = cur_r[AW-1:0];
          dst_nxt   = cur_r[AW-1:0];
          cur_nxt   = cur_r + CW'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    end_r      <= end_nxt;
    pos_r      <= pos_nxt;
    dst_r      <= dst_nxt;
    val_r      <= val_nxt;
    res_ok_r   <= res_ok_nxt;
    res_rd_r   <= res_rd_nxt;
    res_fnd_r  <= res_fnd_nxt;
    res_fidx_r <= res_fidx_nxt;
    if (out_load) begin
      out_ok            <= res_ok_r;
      out_read_value    <= res_rd_r;
      out_found         <= res_fnd_r;
      out_found_index   <= res_fidx_r;
      out_element_count <= CNT_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule
